FILE: sv/kmt_pkg.sv
`default_nettype none
package kmt_pkg;

	localparam int LOCK_COUNT_DEF      = 16;
	localparam int QUEUE_DEPTH_DEF     = 8;
	localparam int PROCESS_ID_BITS_DEF = 8;

	localparam logic [1:0] CMD_INIT    = 2'd0;
	localparam logic [1:0] CMD_ACQUIRE = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_NEW      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_ACQUIRED = 3'd3;
	localparam logic [2:0] ST_BLOCKED  = 3'd4;
	localparam logic [2:0] ST_FREED    = 3'd5;
	localparam logic [2:0] ST_HANDED   = 3'd6;
	localparam logic [2:0] ST_ERROR    = 3'd7;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] lock_key;
		logic [3:0]         lock_index;
		logic [7:0]         caller_process;
	} kmt_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] result_index;
		logic       woken_valid;
		logic [7:0] woken_process;
	} kmt_out_t;

	typedef struct packed {
		logic     done;
		kmt_out_t res;
	} kmt_rsp_t;

endpackage
`default_nettype wire

FILE: sv/kmt_scan.sv
`default_nettype none
module kmt_scan import kmt_pkg::*; #(
	parameter int LOCK_COUNT = LOCK_COUNT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     go,
	input  wire kmt_in_t  item,
	output kmt_rsp_t      rsp
);

	localparam int IW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int CW = $clog2(LOCK_COUNT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(LOCK_COUNT - 1);

	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  cnt;
	} entry_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_t;

	state_t              state_q;
	kmt_rsp_t            rsp_q;
	logic [CW-1:0]       issue_q;
	logic                pend_s1;
	logic [LOCK_COUNT-1:0] ent_vld_q;
	logic                free_hit_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       upd_idx_q;
	logic [7:0]          upd_cnt_q;
	logic [2:0]          upd_st_q;
	logic [31:0]         key_q;

	entry_t              ent_mem [LOCK_COUNT];
	entry_t              ent_rd_s1;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic [IW-1:0]       rd_addr;
	logic                ent_we;

	entry_t              eff;
	logic                key_hit;
	logic                cnt_free;
	logic                last;
	logic [31:0]         idx_ext;

	function automatic logic [7:0] sat_inc(input logic [7:0] c);
		return (c == 8'hFF) ? c : c + 8'd1;
	endfunction

	assign rd_addr  = issue_q[IW-1:0];
	assign ent_we   = (state_q == S_UPD);
	assign eff      = vld_s1 ? ent_rd_s1 : '0;
	assign key_hit  = pend_s1 && (eff.key == key_q);
	assign cnt_free = pend_s1 && (eff.cnt == 8'd0);
	assign last     = pend_s1 && (idx_s1 == LAST_IDX);
	assign idx_ext  = 32'(upd_idx_q);
	assign rsp      = rsp_q;

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[upd_idx_q] <= '{key: key_q, cnt: upd_cnt_q};
		ent_rd_s1 <= ent_mem[rd_addr];
		vld_s1    <= ent_vld_q[rd_addr];
		idx_s1    <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rsp_q      <= '0;
			issue_q    <= '0;
			pend_s1    <= 1'b0;
			ent_vld_q  <= '0;
			free_hit_q <= 1'b0;
			free_idx_q <= '0;
			upd_idx_q  <= '0;
			upd_cnt_q  <= '0;
			upd_st_q   <= ST_FOUND;
			key_q      <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (go) begin
						key_q      <= item.lock_key;
						issue_q    <= '0;
						free_hit_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= (issue_q < CW'(LOCK_COUNT));
					if (issue_q < CW'(LOCK_COUNT))
						issue_q <= issue_q + CW'(1);
					if (key_hit) begin
						upd_idx_q <= idx_s1;
						upd_cnt_q <= sat_inc(eff.cnt);
						upd_st_q  <= ST_FOUND;
						state_q   <= S_UPD;
					end else begin
						if (cnt_free && !free_hit_q) begin
							free_hit_q <= 1'b1;
							free_idx_q <= idx_s1;
						end
						if (last) begin
							if (free_hit_q || cnt_free) begin
								upd_idx_q <= free_hit_q ? free_idx_q : idx_s1;
								upd_cnt_q <= 8'd1;
								upd_st_q  <= ST_NEW;
								state_q   <= S_UPD;
							end else begin
								rsp_q.done <= 1'b1;
								rsp_q.res  <= '{status: ST_FULL, default: '0};
								state_q    <= S_IDLE;
							end
						end
					end
				end
				S_UPD: begin
					ent_vld_q[upd_idx_q] <= 1'b1;
					rsp_q.done <= 1'b1;
					rsp_q.res  <= '{status: upd_st_q, result_index: idx_ext[3:0],
						default: '0};
					pend_s1    <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/kmt_queue.sv
`default_nettype none
module kmt_queue import kmt_pkg::*; #(
	parameter int LOCK_COUNT      = LOCK_COUNT_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
	parameter int PROCESS_ID_BITS = PROCESS_ID_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     go,
	input  wire kmt_in_t  item,
	output kmt_rsp_t      rsp
);

	localparam int IW    = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
	localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SW    = NW + 1;
	localparam int PID_W = (PROCESS_ID_BITS < 8) ? PROCESS_ID_BITS : 8;
	localparam int WDEP  = LOCK_COUNT * QUEUE_DEPTH;
	localparam int AW    = (WDEP > 1) ? $clog2(WDEP) : 1;

	typedef struct packed {
		logic          locked;
		logic [HW-1:0] head;
		logic [NW-1:0] count;
	} qs_t;

	typedef enum logic [1:0] {Q_IDLE, Q_READ, Q_EVAL, Q_WAKE} state_t;

	state_t                state_q;
	kmt_rsp_t              rsp_q;
	logic [LOCK_COUNT-1:0] qs_vld_q;
	logic [IW-1:0]         idx_q;
	logic [PID_W-1:0]      pid_q;
	logic                  acq_q;

	qs_t                   qs_mem [LOCK_COUNT];
	logic [PID_W-1:0]      wt_mem [WDEP];
	qs_t                   qs_rd_s1;
	logic                  qs_vld_s1;
	logic [PID_W-1:0]      wt_rd_s1;

	qs_t                   eff;
	qs_t                   qs_wdata;
	logic                  qs_we;
	logic                  wt_we;
	logic [2:0]            ev_st;
	logic                  ev_wake;
	logic [AW-1:0]         base;
	logic [AW-1:0]         wt_raddr;
	logic [AW-1:0]         wt_waddr;

	function automatic logic [HW-1:0] wrap(input logic [HW-1:0] h, input logic [NW-1:0] c);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(c);
		if (s >= SW'(QUEUE_DEPTH))
			s = s - SW'(QUEUE_DEPTH);
		return HW'(s);
	endfunction

	assign eff      = qs_vld_s1 ? qs_rd_s1 : '0;
	assign base     = AW'(idx_q) * AW'(QUEUE_DEPTH);
	assign wt_raddr = base + AW'(eff.head);
	assign wt_waddr = base + AW'(wrap(eff.head, eff.count));
	assign rsp      = rsp_q;

	always_comb begin
		qs_wdata = eff;
		qs_we    = 1'b0;
		wt_we    = 1'b0;
		ev_st    = ST_ERROR;
		ev_wake  = 1'b0;
		if (acq_q) begin
			if (!eff.locked) begin
				qs_wdata.locked = 1'b1;
				qs_we = 1'b1;
				ev_st = ST_ACQUIRED;
			end else if (eff.count < NW'(QUEUE_DEPTH)) begin
				qs_wdata.count = eff.count + NW'(1);
				qs_we = 1'b1;
				wt_we = 1'b1;
				ev_st = ST_BLOCKED;
			end
		end else begin
			if (eff.count == '0) begin
				qs_wdata.locked = 1'b0;
				qs_we = 1'b1;
				ev_st = ST_FREED;
			end else begin
				qs_wdata.locked = 1'b1;
				qs_wdata.head   = wrap(eff.head, NW'(1));
				qs_wdata.count  = eff.count - NW'(1);
				qs_we   = 1'b1;
				ev_wake = 1'b1;
				ev_st   = ST_HANDED;
			end
		end
		if (state_q != Q_EVAL) begin
			qs_we = 1'b0;
			wt_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (qs_we)
			qs_mem[idx_q] <= qs_wdata;
		if (wt_we)
			wt_mem[wt_waddr] <= pid_q;
		qs_rd_s1  <= qs_mem[idx_q];
		qs_vld_s1 <= qs_vld_q[idx_q];
		wt_rd_s1  <= wt_mem[wt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= Q_IDLE;
			rsp_q    <= '0;
			qs_vld_q <= '0;
			idx_q    <= '0;
			pid_q    <= '0;
			acq_q    <= 1'b0;
		end else begin
			rsp_q.done <= 1'b0;
			if (qs_we)
				qs_vld_q[idx_q] <= 1'b1;
			unique case (state_q)
				Q_IDLE: begin
					if (go) begin
						idx_q   <= IW'(item.lock_index);
						pid_q   <= item.caller_process[PID_W-1:0];
						acq_q   <= (item.command == CMD_ACQUIRE);
						state_q <= Q_READ;
					end
				end
				Q_READ: state_q <= Q_EVAL;
				Q_EVAL: begin
					if (ev_wake) begin
						state_q <= Q_WAKE;
					end else begin
						rsp_q.done <= 1'b1;
						rsp_q.res  <= '{status: ev_st, default: '0};
						state_q    <= Q_IDLE;
					end
				end
				Q_WAKE: begin
					rsp_q.done <= 1'b1;
					rsp_q.res  <= '{status: ST_HANDED, result_index: 4'd0, woken_valid: 1'b1,
						woken_process: 8'(wt_rd_s1)};
					state_q    <= Q_IDLE;
				end
				default: state_q <= Q_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/keyed_mutex_table_top.sv
// Init: the key/count table scan reads and compares one entry per cycle,
//   and stops early when the key matches.
// Acquire and release: queue read and evaluate states, plus a wake state when a release hands the lock to a waiter.
// Bad command or index: result in the cycle after start. One transaction at a time.
// Result strobe done is high for one cycle; the receiver cannot stall.
// Reset clears all lock state at once through per-entry valid bits; no clear pass.
`default_nettype none
module keyed_mutex_table_top import kmt_pkg::*; #(
	parameter int LOCK_COUNT      = LOCK_COUNT_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF,
	parameter int PROCESS_ID_BITS = PROCESS_ID_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire kmt_in_t request,
	output logic         done,
	output kmt_out_t     result
);

	typedef enum logic {T_IDLE, T_WAIT} state_t;

	state_t   state_q;
	logic     done_q;
	kmt_out_t result_q;
	kmt_in_t  item_q;
	logic     go_scan_q;
	logic     go_queue_q;
	kmt_rsp_t scan_rsp;
	kmt_rsp_t queue_rsp;
	logic     accept;
	logic     idx_ok;

	assign busy   = (state_q != T_IDLE);
	assign done   = done_q;
	assign result = result_q;
	assign accept = start && !busy;
	assign idx_ok = (32'(request.lock_index) < 32'(LOCK_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			done_q     <= 1'b0;
			result_q   <= '0;
			item_q     <= '0;
			go_scan_q  <= 1'b0;
			go_queue_q <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			go_scan_q  <= 1'b0;
			go_queue_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						item_q <= request;
						if (request.command == CMD_INIT) begin
							go_scan_q <= 1'b1;
							state_q   <= T_WAIT;
						end else if ((request.command == CMD_ACQUIRE ||
								request.command == CMD_RELEASE) && idx_ok) begin
							go_queue_q <= 1'b1;
							state_q    <= T_WAIT;
						end else begin
							done_q   <= 1'b1;
							result_q <= '{status: ST_ERROR, default: '0};
						end
					end
				end
				T_WAIT: begin
					if (scan_rsp.done || queue_rsp.done) begin
						done_q   <= 1'b1;
						result_q <= scan_rsp.done ? scan_rsp.res : queue_rsp.res;
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	kmt_scan #(
		.LOCK_COUNT(LOCK_COUNT)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go_scan_q),
		.item  (item_q),
		.rsp   (scan_rsp)
	);

	kmt_queue #(
		.LOCK_COUNT     (LOCK_COUNT),
		.QUEUE_DEPTH    (QUEUE_DEPTH),
		.PROCESS_ID_BITS(PROCESS_ID_BITS)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go_queue_q),
		.item  (item_q),
		.rsp   (queue_rsp)
	);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still in flight");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted transaction neither started nor answered");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_rsp.done && queue_rsp.done))
		else $error("both units answered in the same cycle");

	a_wake_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.woken_valid) |-> (result.status == ST_HANDED))
		else $error("woken process reported without a handover");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
	import kmt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         DRAIN_WAIT  = 40;

	logic     clk;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	kmt_in_t  request = '0;
	logic     busy;
	logic     done;
	kmt_out_t result;

	keyed_mutex_table_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// lock table shadow
	logic [31:0] key_table  [LOCK_COUNT_DEF];
	logic [7:0]  use_table  [LOCK_COUNT_DEF];
	logic        held       [LOCK_COUNT_DEF];
	logic [7:0]  waiters    [LOCK_COUNT_DEF][QUEUE_DEPTH_DEF];
	int          head_ptr   [LOCK_COUNT_DEF];
	int          waiting    [LOCK_COUNT_DEF];

	kmt_in_t     lock_calls[$];
	kmt_out_t    lock_replies[$];
	logic [31:0] key_pool[20];

	int calls_total;
	int calls_taken;
	int replies_seen;
	int failures;
	int idle_left;
	bit calm;
	int status_tally[8];

	initial begin
		for (int i = 0; i < LOCK_COUNT_DEF; i++) begin
			key_table[i] = '0;
			use_table[i] = '0;
			held[i]      = 1'b0;
			head_ptr[i]  = 0;
			waiting[i]   = 0;
		end
	end

	function automatic kmt_out_t apply_lock_call(input kmt_in_t call);
		kmt_out_t reply;
		bit       hit;
		int       i;
		int       x;
		int       slot;
		reply = '0;
		hit   = 1'b0;
		x     = 32'(call.lock_index);
		if (call.command == CMD_INIT) begin
			for (i = 0; i < LOCK_COUNT_DEF; i++) begin
				if (!hit && key_table[i] == $unsigned(call.lock_key)) begin
					hit = 1'b1;
					if (use_table[i] != 8'hFF)
						use_table[i] = use_table[i] + 8'd1;
					reply.status       = ST_FOUND;
					reply.result_index = i[3:0];
				end
			end
			for (i = 0; i < LOCK_COUNT_DEF; i++) begin
				if (!hit && use_table[i] == 8'd0) begin
					hit = 1'b1;
					use_table[i]       = 8'd1;
					key_table[i]       = call.lock_key;
					reply.status       = ST_NEW;
					reply.result_index = i[3:0];
				end
			end
			if (!hit)
				reply.status = ST_FULL;
		end else if (call.command == CMD_ACQUIRE || call.command == CMD_RELEASE) begin
			if (x >= LOCK_COUNT_DEF) begin
				reply.status = ST_ERROR;
			end else if (call.command == CMD_ACQUIRE) begin
				if (!held[x]) begin
					held[x]      = 1'b1;
					reply.status = ST_ACQUIRED;
				end else if (waiting[x] >= QUEUE_DEPTH_DEF) begin
					reply.status = ST_ERROR;
				end else begin
					slot = (head_ptr[x] + waiting[x]) % QUEUE_DEPTH_DEF;
					waiters[x][slot] = call.caller_process;
					waiting[x]++;
					reply.status = ST_BLOCKED;
				end
			end else if (waiting[x] == 0) begin
				held[x]      = 1'b0;
				reply.status = ST_FREED;
			end else begin
				reply.woken_process = waiters[x][head_ptr[x]];
				reply.woken_valid   = 1'b1;
				reply.status        = ST_HANDED;
				head_ptr[x]         = (head_ptr[x] + 1) % QUEUE_DEPTH_DEF;
				waiting[x]--;
				held[x]             = 1'b1;
			end
		end else begin
			reply.status = ST_ERROR;
		end
		return reply;
	endfunction

	task automatic push_call(input logic [1:0] cmd, input logic [31:0] key,
			input logic [3:0] idx, input logic [7:0] pid);
		kmt_in_t call;
		call.command        = cmd;
		call.lock_key       = key;
		call.lock_index     = idx;
		call.caller_process = pid;
		lock_calls.push_back(call);
	endtask

	task automatic queue_random_calls(input int n);
		kmt_in_t call;
		int      acquire_pct;
		int      r;
		int      k;
		acquire_pct = 50;
		for (k = 0; k < n; k++) begin
			if (k % 50 == 0)
				acquire_pct = $urandom_range(20, 70);
			call.lock_key       = $urandom;
			call.lock_index     = 4'($urandom_range(15));
			call.caller_process = 8'($urandom_range(255));
			if ($urandom_range(9) < 7)
				call.lock_index = 4'($urandom_range(3));
			r = $urandom_range(99);
			if (r < 4) begin
				call.command = CMD_UNUSED;
			end else if (r < 22) begin
				call.command = CMD_INIT;
				if ($urandom_range(9) != 0)
					call.lock_key = key_pool[$urandom_range(19)];
			end else if (r < 22 + acquire_pct * 78 / 100) begin
				call.command = CMD_ACQUIRE;
			end else begin
				call.command = CMD_RELEASE;
			end
			lock_calls.push_back(call);
		end
	endtask

	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic note_failure(input string msg);
		failures++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// driver
	always @(posedge clk) begin
		kmt_in_t noise;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (start) begin
				lock_replies.push_back(apply_lock_call(request));
				calls_taken++;
				if (calls_taken % 100 == 0)
					calm = ($urandom_range(3) == 0);
				idle_left = calm ? 0 : draw_gap();
			end
			if (idle_left > 0 || lock_calls.size() == 0) begin
				if (idle_left > 0)
					idle_left--;
				noise.command        = 2'($urandom_range(3));
				noise.lock_key       = $urandom;
				noise.lock_index     = 4'($urandom_range(15));
				noise.caller_process = 8'($urandom_range(255));
				request <= noise;
				start   <= 1'b0;
			end else begin
				request <= lock_calls.pop_front();
				start   <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		kmt_out_t want;
		if (arst_n && done) begin
			if (lock_replies.size() == 0) begin
				note_failure($sformatf("result with no transaction pending: %p", result));
			end else begin
				want = lock_replies.pop_front();
				replies_seen++;
				status_tally[want.status]++;
				if (result.status !== want.status)
					note_failure($sformatf("reply %0d status %0d, want %0d",
						replies_seen, result.status, want.status));
				if (result.result_index !== want.result_index)
					note_failure($sformatf("reply %0d result_index %0d, want %0d",
						replies_seen, result.result_index, want.result_index));
				if (result.woken_valid !== want.woken_valid)
					note_failure($sformatf("reply %0d woken_valid %0b, want %0b",
						replies_seen, result.woken_valid, want.woken_valid));
				if (result.woken_process !== want.woken_process)
					note_failure($sformatf("reply %0d woken_process %0h, want %0h",
						replies_seen, result.woken_process, want.woken_process));
			end
		end
	end

	initial begin
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("testbench failed");
		$finish;
	end

	initial begin
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h8000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < 20; i++)
			key_pool[i] = $urandom;

		// zero key hits an unused entry, then claims and lookups
		push_call(CMD_INIT, key_pool[0], 4'd0, 8'd0);
		push_call(CMD_INIT, key_pool[1], 4'd0, 8'd0);
		push_call(CMD_INIT, key_pool[0], 4'd15, 8'hFF);
		push_call(CMD_INIT, key_pool[2], 4'd0, 8'd0);
		push_call(CMD_INIT, key_pool[3], 4'd0, 8'd0);
		push_call(CMD_INIT, key_pool[1], 4'd0, 8'd0);
		// handover order, then release of a free lock
		push_call(CMD_ACQUIRE, 32'h0, 4'd15, 8'h00);
		push_call(CMD_ACQUIRE, 32'h0, 4'd15, 8'hFF);
		push_call(CMD_ACQUIRE, 32'h0, 4'd15, 8'hA5);
		push_call(CMD_RELEASE, 32'h0, 4'd15, 8'h00);
		push_call(CMD_RELEASE, 32'h0, 4'd15, 8'h00);
		push_call(CMD_RELEASE, 32'h0, 4'd15, 8'h00);
		push_call(CMD_RELEASE, 32'hFFFF_FFFF, 4'd15, 8'hFF);
		push_call(CMD_UNUSED, 32'h8000_0000, 4'd15, 8'hFF);
		// fill one waiter queue, overflow it, then hand over
		push_call(CMD_ACQUIRE, 32'h0, 4'd0, 8'h5A);
		for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
			push_call(CMD_ACQUIRE, 32'h0, 4'd0, 8'(i * 37 + 1));
		push_call(CMD_ACQUIRE, 32'h0, 4'd0, 8'hC3);
		push_call(CMD_RELEASE, 32'h0, 4'd0, 8'h00);

		queue_random_calls(600);
		// drive one use count past saturation, then try a fresh key
		for (int i = 0; i < 270; i++)
			push_call(CMD_INIT, key_pool[1], 4'($urandom_range(15)), 8'($urandom_range(255)));
		push_call(CMD_INIT, $urandom, 4'd0, 8'd0);
		queue_random_calls(700);
		calls_total = lock_calls.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (calls_taken < calls_total)
			@(posedge clk);
		while (lock_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d lock calls, %0d replies checked, %0d mismatches",
			calls_taken, replies_seen, failures);
		$display({"found %0d new %0d full %0d acquired %0d ",
			"blocked %0d freed %0d handed %0d error %0d"},
			status_tally[ST_FOUND], status_tally[ST_NEW], status_tally[ST_FULL],
			status_tally[ST_ACQUIRED], status_tally[ST_BLOCKED], status_tally[ST_FREED],
			status_tally[ST_HANDED], status_tally[ST_ERROR]);
		if (failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
sv/kmt_pkg.sv
sv/kmt_scan.sv
sv/kmt_queue.sv
sv/keyed_mutex_table_top.sv
bench/testbench.sv
